// File: hw/rtl/dfpe_pkg.sv
// DShot frame pulse encoder package: shared types, constants and the frame builder.
// No dependencies; used by every module of the encoder.
`timescale 1ns / 1ps

package dfpe_pkg;

	localparam int FRAME_W = 16;
	localparam int TICKS_W = 16;
	localparam int THR_W   = 11;
	localparam int SLOT_W  = 6;

	localparam logic [SLOT_W-1:0]  LAST_SLOT      = 6'd33;
	localparam logic [SLOT_W-1:0]  FIRST_PAD_SLOT = 6'd32;
	localparam logic [FRAME_W-1:0] ZERO_FRAME     = 16'h000F;
	localparam logic [THR_W-1:0]   THROTTLE_MASK  = 11'h7FF;
	localparam logic [3:0]         NIBBLE_MASK    = 4'hF;

	localparam logic [TICKS_W-1:0] ONE_TICKS_RST  = 16'd105;
	localparam logic [TICKS_W-1:0] ZERO_TICKS_RST = 16'd52;

	// Register indexes of the configuration port
	localparam logic CFG_ONE_BIT_TICKS  = 1'b0;
	localparam logic CFG_ZERO_BIT_TICKS = 1'b1;

	typedef struct packed {
		logic               valid;
		logic [FRAME_W-1:0] frame;
	} frame_req_t;

	typedef struct packed {
		logic               write_en;
		logic               index;
		logic [TICKS_W-1:0] wdata;
	} cfg_wr_t;

	function automatic logic [FRAME_W-1:0] build_frame(input logic [THR_W-1:0] thr,
		input logic req);
		logic [11:0] word12;
		logic [3:0]  csum;
		word12 = {thr & THROTTLE_MASK, req};
		csum   = ~(word12[3:0] ^ word12[7:4] ^ word12[11:8]) & NIBBLE_MASK;
		if (thr == '0) begin
			build_frame = ZERO_FRAME;
		end else begin
			build_frame = {word12, csum};
		end
	endfunction

endpackage

// File: hw/rtl/dfpe_front.sv
// Front stage: accepts throttle requests and registers the built frame.
// Depends on dfpe_pkg.
`timescale 1ns / 1ps

module dfpe_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [dfpe_pkg::THR_W-1:0] throttle,
	input  logic                       telemetry_request,
	output dfpe_pkg::frame_req_t       push,
	input  logic                       push_ready
);
	import dfpe_pkg::*;

	logic               valid_s1;
	logic [FRAME_W-1:0] frame_s1;

	assign in_ready = !valid_s1 || push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			frame_s1 <= build_frame(throttle, telemetry_request);
		end
	end

	assign push.valid = valid_s1;
	assign push.frame = frame_s1;

endmodule

// File: hw/rtl/dfpe_queue.sv
// Two-entry frame queue between the front stage and the slot sequencer.
// Depends on dfpe_pkg.
`timescale 1ns / 1ps

module dfpe_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dfpe_pkg::frame_req_t push,
	output logic                 push_ready,
	output dfpe_pkg::frame_req_t head,
	input  logic                 pop
);
	import dfpe_pkg::*;

	logic [FRAME_W-1:0] entry_q [2];
	logic               wr_ptr_q;
	logic               rd_ptr_q;
	logic [1:0]         count_q;
	logic               do_push;
	logic               do_pop;

	assign push_ready = (count_q != 2'd2);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (count_q != 2'd0);

	assign head.valid = (count_q != 2'd0);
	assign head.frame = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 2'd1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			entry_q[wr_ptr_q] <= push.frame;
		end
	end

endmodule

// File: hw/rtl/dfpe_back.sv
// Back stage: holds the tick registers and steps through the 34 slots of each frame.
// Depends on dfpe_pkg.
`timescale 1ns / 1ps

module dfpe_back (
	input  logic                         clk,
	input  logic                         arst_n,
	input  dfpe_pkg::cfg_wr_t            cfg,
	input  dfpe_pkg::frame_req_t         head,
	output logic                         pop,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dfpe_pkg::TICKS_W-1:0] compare_ticks,
	output logic [dfpe_pkg::FRAME_W-1:0] frame_word,
	output logic                         is_last
);
	import dfpe_pkg::*;

	logic [TICKS_W-1:0] one_ticks_q;
	logic [TICKS_W-1:0] zero_ticks_q;
	logic               active_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [FRAME_W-1:0] frame_q;
	logic               out_valid_q;
	logic [TICKS_W-1:0] ticks_q;
	logic [FRAME_W-1:0] word_q;
	logic               last_q;

	logic               advance;
	logic               emit;
	logic [SLOT_W-1:0]  cur_slot;
	logic [FRAME_W-1:0] cur_frame;
	logic               cur_bit;
	logic [TICKS_W-1:0] cur_ticks;

	assign advance = !out_valid_q || out_ready;
	assign emit    = advance && (active_q || head.valid);
	assign pop     = advance && !active_q && head.valid;

	assign cur_slot  = active_q ? slot_q : '0;
	assign cur_frame = active_q ? frame_q : head.frame;
	// MSB first: even slot k carries frame bit 15 - k/2
	assign cur_bit   = cur_frame[~cur_slot[4:1]];

	always_comb begin
		if (cur_slot < FIRST_PAD_SLOT && !cur_slot[0]) begin
			cur_ticks = cur_bit ? one_ticks_q : zero_ticks_q;
		end else begin
			cur_ticks = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			one_ticks_q  <= ONE_TICKS_RST;
			zero_ticks_q <= ZERO_TICKS_RST;
		end else if (cfg.write_en) begin
			case (cfg.index)
				CFG_ONE_BIT_TICKS:  one_ticks_q  <= cfg.wdata;
				CFG_ZERO_BIT_TICKS: zero_ticks_q <= cfg.wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			slot_q      <= '0;
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
			if (emit) begin
				// drop back to the queue after the last slot
				active_q <= (cur_slot != LAST_SLOT);
				slot_q   <= cur_slot + 6'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			frame_q <= head.frame;
		end
		if (emit) begin
			ticks_q <= cur_ticks;
			word_q  <= cur_frame;
			last_q  <= (cur_slot == LAST_SLOT);
		end
	end

	assign out_valid     = out_valid_q;
	assign compare_ticks = ticks_q;
	assign frame_word    = word_q;
	assign is_last       = last_q;

endmodule

// File: hw/rtl/dshot_frame_pulse_encoder.sv
// Top level of the bidirectional DShot frame pulse encoder.
// Depends on dfpe_pkg, dfpe_front, dfpe_queue and dfpe_back.
//
// Usage:
//   Input channel (in_valid/in_ready, throttle, telemetry_request) takes one
//   request per frame. The output channel (out_valid/out_ready) delivers 34
//   slots per request: compare_ticks, the full frame_word and is_last on slot 33.
//   Even slots 0..30 carry one_bit_ticks or zero_bit_ticks for frame bits 15..0,
//   odd slots and the two closing slots carry zero.
//   Configuration: cfg_write_en with cfg_index 0 (one-bit ticks) or 1 (zero-bit
//   ticks) and cfg_wdata; write only while the encoder is idle.
//   Path: a request passes the front register, queue and output register.
//   Throughput: one slot per cycle while out_ready is high; the slot
//   sequencer in the back stage sets the pace. A frame register and a
//   two-entry queue hold later requests while a frame is being sent.
//   Stall: when out_ready is low the output register holds its slot, the
//   sequencer waits, and in_ready falls once the queue and front stage are full.
//   Reset: arst_n clears all queued and in-flight work and restores the tick
//   registers to 105 and 52.
`timescale 1ns / 1ps

module dshot_frame_pulse_encoder (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_write_en,
	input  logic                         cfg_index,
	input  logic [dfpe_pkg::TICKS_W-1:0] cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [dfpe_pkg::THR_W-1:0]   throttle,
	input  logic                         telemetry_request,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [dfpe_pkg::TICKS_W-1:0] compare_ticks,
	output logic [dfpe_pkg::FRAME_W-1:0] frame_word,
	output logic                         is_last
);
	import dfpe_pkg::*;

	frame_req_t push;
	frame_req_t head;
	cfg_wr_t    cfg;
	logic       push_ready;
	logic       pop;

	assign cfg.write_en = cfg_write_en;
	assign cfg.index    = cfg_index;
	assign cfg.wdata    = cfg_wdata;

	dfpe_front u_front (
		.clk               (clk),
		.arst_n            (arst_n),
		.in_valid          (in_valid),
		.in_ready          (in_ready),
		.throttle          (throttle),
		.telemetry_request (telemetry_request),
		.push              (push),
		.push_ready        (push_ready)
	);

	dfpe_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	dfpe_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.head          (head),
		.pop           (pop),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.compare_ticks (compare_ticks),
		.frame_word    (frame_word),
		.is_last       (is_last)
	);

endmodule

// File: verif/dshot_frame_pulse_encoder_test.sv
// Self-checking testbench for dshot_frame_pulse_encoder: frames and slot trains.
// Uses a scoreboard class that expands each request into its 34 expected slots.
// Depends on dfpe_pkg and the encoder RTL only.
`timescale 1ns / 1ps

module dshot_frame_pulse_encoder_test;
	import dfpe_pkg::*;

	typedef struct {
		logic [TICKS_W-1:0] ticks;
		logic [FRAME_W-1:0] frame;
		logic               last;
	} slot_t;

	class slot_scoreboard;
		slot_t              pending[$];
		logic [TICKS_W-1:0] one_ticks;
		logic [TICKS_W-1:0] zero_ticks;
		int                 errors;

		function new();
			one_ticks  = ONE_TICKS_RST;
			zero_ticks = ZERO_TICKS_RST;
			errors     = 0;
		endfunction

		function void set_ticks(input logic [TICKS_W-1:0] one_val,
			input logic [TICKS_W-1:0] zero_val);
			one_ticks  = one_val;
			zero_ticks = zero_val;
		endfunction

		// Throttle and flag on top, inverted nibble XOR below
		function logic [FRAME_W-1:0] dshot_frame(input logic [THR_W-1:0] thr,
			input logic req);
			logic [11:0] word;
			logic [3:0]  csum;
			word = {thr, req};
			csum = ~(word[11:8] ^ word[7:4] ^ word[3:0]);
			if (thr == '0) begin
				return ZERO_FRAME;
			end
			return {word, csum};
		endfunction

		function void note_request(input logic [THR_W-1:0] thr, input logic req);
			logic [FRAME_W-1:0] frame;
			slot_t              s;
			frame = dshot_frame(thr, req);
			for (int b = FRAME_W - 1; b >= 0; b--) begin
				s.ticks = frame[b] ? one_ticks : zero_ticks;
				s.frame = frame;
				s.last  = 1'b0;
				pending.push_back(s);
				s.ticks = '0;
				pending.push_back(s);
			end
			s.ticks = '0;
			s.frame = frame;
			s.last  = 1'b0;
			pending.push_back(s);
			s.last = 1'b1;
			pending.push_back(s);
		endfunction

		function void check_slot(input logic [TICKS_W-1:0] ticks,
			input logic [FRAME_W-1:0] frame, input logic last);
			slot_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 100) begin
					$error("unexpected slot: compare_ticks %0d frame_word %h", ticks, frame);
				end
				return;
			end
			e = pending.pop_front();
			if (ticks !== e.ticks) begin
				errors++;
				if (errors <= 100) begin
					$error("compare_ticks: expected %0d, got %0d", e.ticks, ticks);
				end
			end
			if (frame !== e.frame) begin
				errors++;
				if (errors <= 100) begin
					$error("frame_word: expected %h, got %h", e.frame, frame);
				end
			end
			if (last !== e.last) begin
				errors++;
				if (errors <= 100) begin
					$error("is_last: expected %b, got %b", e.last, last);
				end
			end
		endfunction

		function int pending_slots();
			return pending.size();
		endfunction
	endclass

	logic               clk               = 1'b0;
	logic               arst_n            = 1'b0;
	logic               cfg_write_en      = 1'b0;
	logic               cfg_index         = CFG_ONE_BIT_TICKS;
	logic [TICKS_W-1:0] cfg_wdata         = '0;
	logic               in_valid          = 1'b0;
	logic               in_ready;
	logic [THR_W-1:0]   throttle          = '0;
	logic               telemetry_request = 1'b0;
	logic               out_valid;
	logic               out_ready         = 1'b0;
	logic [TICKS_W-1:0] compare_ticks;
	logic [FRAME_W-1:0] frame_word;
	logic               is_last;

	bit             gaps_on   = 1'b1;
	bit             stalls_on = 1'b1;
	slot_scoreboard sb        = new();

	dshot_frame_pulse_encoder uut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_write_en     (cfg_write_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.throttle         (throttle),
		.telemetry_request(telemetry_request),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.compare_ticks    (compare_ticks),
		.frame_word       (frame_word),
		.is_last          (is_last)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		out_ready <= !stalls_on || ($urandom_range(99) >= 10);
	end

	always @(posedge clk) begin
		if (out_valid && out_ready) begin
			sb.check_slot(compare_ticks, frame_word, is_last);
		end
	end

	// Hold valid and payload until the request is taken
	task automatic send_request(input logic [THR_W-1:0] thr, input logic req);
		while (gaps_on && $urandom_range(99) < 10) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid          <= 1'b1;
		throttle          <= thr;
		telemetry_request <= req;
		do @(posedge clk); while (!in_ready);
		sb.note_request(thr, req);
	endtask

	task automatic send_random();
		int               pick;
		logic [THR_W-1:0] thr;
		pick = $urandom_range(9);
		if (pick == 0) begin
			thr = '0;
		end else if (pick == 1) begin
			thr = '1;
		end else begin
			thr = THR_W'($urandom_range(2047));
		end
		send_request(thr, 1'($urandom_range(1)));
	endtask

	task automatic drain_slots();
		in_valid <= 1'b0;
		while (sb.pending_slots() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_ticks(input logic [TICKS_W-1:0] one_val,
		input logic [TICKS_W-1:0] zero_val);
		cfg_write_en <= 1'b1;
		cfg_index    <= CFG_ONE_BIT_TICKS;
		cfg_wdata    <= one_val;
		@(posedge clk);
		cfg_index <= CFG_ZERO_BIT_TICKS;
		cfg_wdata <= zero_val;
		@(posedge clk);
		cfg_write_en <= 1'b0;
		sb.set_ticks(one_val, zero_val);
	endtask

	task automatic run_phase(input logic [TICKS_W-1:0] one_val,
		input logic [TICKS_W-1:0] zero_val, input int count);
		write_ticks(one_val, zero_val);
		repeat (count) send_random();
		drain_slots();
	endtask

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset tick values: zero throttle with either flag, extremes, single bits, mixed patterns
		send_request(11'd0, 1'b0);
		send_request(11'd0, 1'b1);
		send_request(11'h7FF, 1'b0);
		send_request(11'h7FF, 1'b1);
		send_request(11'd1, 1'b0);
		send_request(11'd1, 1'b1);
		for (int k = 0; k < THR_W; k++) begin
			send_request(11'd1 << k, k[0]);
		end
		send_request(11'h555, 1'b1);
		send_request(11'h2AA, 1'b0);
		send_request(11'd48, 1'b1);
		drain_slots();

		run_phase(16'hFFFF, 16'h0000, 40);
		run_phase(16'h0000, 16'hFFFF, 40);
		run_phase(16'hFFFF, 16'hFFFF, 30);
		run_phase(16'h0000, 16'h0000, 30);

		// Back-to-back requests with the sink always ready
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		run_phase(TICKS_W'($urandom_range(65535)), TICKS_W'($urandom_range(65535)), 70);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;

		run_phase(TICKS_W'($urandom_range(65535)), TICKS_W'($urandom_range(65535)), 40);
		run_phase(TICKS_W'($urandom_range(65535)), TICKS_W'($urandom_range(65535)), 40);
		run_phase(ONE_TICKS_RST, ZERO_TICKS_RST, 30);

		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending_slots() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Test completed with failures");
		$finish;
	end

endmodule
